>>> rtl/abfa_pkg.sv
// shared types, widths and codes for the frame allocator
`timescale 1ns / 1ps

package abfa_pkg;

   localparam int REG_ADDR_W  = 48;
   localparam int FRAME_NUM_W = 36;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int COUNT_W     = 4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FRAME = 2'd1,
      STATUS_LOADED   = 2'd2
   } status_type;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_FIRST = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_LAST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BOOT_FIRST   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BOOT_LAST    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AREA_COUNT   = 3'd4;

   typedef struct packed {
      logic                  we;
      logic [ENTRY_W-1:0]    idx;
      logic [REG_ADDR_W-1:0] base;
      logic [REG_ADDR_W-1:0] len;
   } load_type;

endpackage

>>> rtl/abfa_if.sv
// request, response and register write channel interfaces
`timescale 1ns / 1ps

interface abfa_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic [abfa_pkg::ENTRY_W-1:0]      entry_index;
   logic [abfa_pkg::REG_ADDR_W-1:0]   area_base;
   logic [abfa_pkg::REG_ADDR_W-1:0]   area_length;

   modport source (output valid, func, entry_index, area_base, area_length, input ready);
   modport sink (input valid, func, entry_index, area_base, area_length, output ready);
endinterface

interface abfa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [abfa_pkg::FRAME_NUM_W-1:0]  frame_number;
   logic [abfa_pkg::STATUS_W-1:0]     status;

   modport source (output valid, frame_number, status, input ready);
   modport sink (input valid, frame_number, status, output ready);
endinterface

interface abfa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [abfa_pkg::CSR_INDEX_W-1:0]  index;
   logic [abfa_pkg::REG_ADDR_W-1:0]   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/abfa_table.sv
// memory area table: frame bounds memory with registered read, non-empty flags
`timescale 1ns / 1ps

module abfa_table #(
   parameter int SLOTS      = 8,
   parameter int ADDR_W     = 48,
   parameter int PAGE_SHIFT = 12,
   localparam int FRAME_W   = ADDR_W - PAGE_SHIFT,
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  abfa_pkg::load_type   load,
   input  logic [IDX_W-1:0]     rd_idx,
   output logic [FRAME_W-1:0]   rd_first,
   output logic [FRAME_W-1:0]   rd_last,
   output logic [SLOTS-1:0]     nonempty
);

   localparam int EW = abfa_pkg::ENTRY_W + 1;

   logic [FRAME_W-1:0] mem_first [SLOTS];
   logic [FRAME_W-1:0] mem_last  [SLOTS];
   logic [FRAME_W-1:0] rd_first_ff;
   logic [FRAME_W-1:0] rd_last_ff;
   logic [SLOTS-1:0]   nonempty_ff;
   logic [SLOTS-1:0]   nonempty_in;

   logic [ADDR_W-1:0]  ea_base;
   logic [ADDR_W-1:0]  ea_len;
   logic [ADDR_W:0]    sum;
   logic [ADDR_W-1:0]  end_addr;
   logic               in_range;
   logic [IDX_W-1:0]   wr_idx;
   logic               wr_en;

   assign ea_base  = load.base[ADDR_W-1:0];
   assign ea_len   = load.len[ADDR_W-1:0];
   assign sum      = {1'b0, ea_base} + {1'b0, ea_len} - {{ADDR_W{1'b0}}, 1'b1};
   assign in_range = {1'b0, load.idx} < EW'(SLOTS);
   assign wr_idx   = load.idx[IDX_W-1:0];
   assign wr_en    = load.we && in_range;

   // saturate the last byte at the top of the address space
   always_comb begin
      if (ea_len == '0) begin
         end_addr = ea_base;
      end else if (sum[ADDR_W]) begin
         end_addr = '1;
      end else begin
         end_addr = sum[ADDR_W-1:0];
      end
   end

   always_comb begin
      nonempty_in = nonempty_ff;
      if (wr_en) begin
         nonempty_in[wr_idx] = (ea_len != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
      end else begin
         nonempty_ff <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_first[wr_idx] <= ea_base[ADDR_W-1:PAGE_SHIFT];
         mem_last[wr_idx]  <= end_addr[ADDR_W-1:PAGE_SHIFT];
      end
      rd_first_ff <= mem_first[rd_idx];
      rd_last_ff  <= mem_last[rd_idx];
   end

   assign rd_first = rd_first_ff;
   assign rd_last  = rd_last_ff;
   assign nonempty = nonempty_ff;

endmodule

>>> rtl/area_bump_frame_allocator.sv
// Load request: ST_LOAD writes the table entry, then ST_DONE registers the response.
// Allocate request: with a usable chosen area, ST_FETCH reads its bounds and ST_CHECK takes the
// cursor frame, skipping each reserved range it hits (at most 2); with no area chosen, ST_SCAN
// first searches the n table entries in use, and ST_CHECK goes back to ALLOC when the area runs out.
// One request is processed at a time; the next is accepted while the response waits to be taken.
// Synchronous active-high reset: empty table, cursor and registers at zero, no area chosen.
`timescale 1ns / 1ps

module area_bump_frame_allocator #(
   parameter int MAX_AREAS  = 8,
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48
) (
   input  logic        clock,
   input  logic        reset,
   abfa_req_if.sink    req_chan,
   abfa_rsp_if.source  rsp_chan,
   abfa_csr_if.sink    csr_chan
);

   localparam int RAW     = abfa_pkg::REG_ADDR_W;
   localparam int EA      = (ADDR_BITS < RAW) ? ADDR_BITS : RAW;
   localparam int FRAME_W = EA - PAGE_SHIFT;
   localparam int CUR_W   = FRAME_W + 1;
   localparam int TOP_SL  = 2 ** abfa_pkg::ENTRY_W;
   localparam int SLOTS   = (MAX_AREAS < TOP_SL) ? MAX_AREAS : TOP_SL;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int FNW     = abfa_pkg::FRAME_NUM_W;
   localparam int CW      = abfa_pkg::COUNT_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LOAD  = 8'b0000_0010,
      ST_ALLOC = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_PICK  = 8'b0001_0000,
      ST_FETCH = 8'b0010_0000,
      ST_CHECK = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type                  state_ff, state_in;

   logic                       func_ff;
   logic [abfa_pkg::ENTRY_W-1:0] idx_ff;
   logic [RAW-1:0]             base_ff;
   logic [RAW-1:0]             len_ff;

   logic [FRAME_W-1:0]         kf_ff, kf_in;
   logic [FRAME_W-1:0]         kl_ff, kl_in;
   logic [FRAME_W-1:0]         bf_ff, bf_in;
   logic [FRAME_W-1:0]         bl_ff, bl_in;
   logic [CW-1:0]              count_ff, count_in;

   logic [CUR_W-1:0]           cursor_ff, cursor_in;
   logic [IDX_W-1:0]           chosen_ff, chosen_in;
   logic                       chosen_valid_ff, chosen_valid_in;

   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       eval_v_ff, eval_v_in;
   logic [IDX_W-1:0]           eval_idx_ff, eval_idx_in;
   logic                       found_ff, found_in;
   logic [FRAME_W-1:0]         best_ff, best_in;

   logic [FRAME_W-1:0]         res_frame_ff, res_frame_in;
   abfa_pkg::status_type       res_status_ff, res_status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FNW-1:0]             rsp_frame_ff, rsp_frame_in;
   logic [abfa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   abfa_pkg::load_type         load;
   logic [IDX_W-1:0]           rd_idx;
   logic [FRAME_W-1:0]         rd_first;
   logic [FRAME_W-1:0]         rd_last;
   logic [SLOTS-1:0]           nonempty;

   logic                       req_take;
   logic [CNT_W-1:0]           n_use;
   logic                       usable;
   logic                       past_end;
   logic                       in_kernel;
   logic                       in_boot;
   logic [CUR_W-1:0]           inc_src;
   logic [CUR_W-1:0]           inc_out;
   logic                       scan_more;
   logic                       take;
   logic                       out_free;

   abfa_table #(
      .SLOTS      (SLOTS),
      .ADDR_W     (EA),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .rd_idx   (rd_idx),
      .rd_first (rd_first),
      .rd_last  (rd_last),
      .nonempty (nonempty)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign load.we   = (state_ff == ST_LOAD);
   assign load.idx  = idx_ff;
   assign load.base = base_ff;
   assign load.len  = len_ff;

   assign rd_idx = (state_ff == ST_SCAN) ? scan_ff[IDX_W-1:0] : chosen_ff;

   assign n_use  = (count_ff > CW'(SLOTS)) ? CNT_W'(SLOTS) : count_ff[CNT_W-1:0];
   assign usable = chosen_valid_ff && (CNT_W'(chosen_ff) < n_use) && nonempty[chosen_ff];

   assign past_end  = {1'b0, rd_last} < cursor_ff;
   assign in_kernel = (cursor_ff >= {1'b0, kf_ff}) && (cursor_ff <= {1'b0, kl_ff});
   assign in_boot   = (cursor_ff >= {1'b0, bf_ff}) && (cursor_ff <= {1'b0, bl_ff});

   // one incrementer serves the frame step and both range skips
   assign inc_src = in_kernel ? {1'b0, kl_ff} : (in_boot ? {1'b0, bl_ff} : cursor_ff);
   assign inc_out = inc_src + CUR_W'(1);

   assign scan_more = scan_ff < n_use;
   assign take      = eval_v_ff && nonempty[eval_idx_ff] && !({1'b0, rd_last} < cursor_ff)
                      && (!found_ff || (rd_first < best_ff));

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // register writes
   always_comb begin
      kf_in    = kf_ff;
      kl_in    = kl_ff;
      bf_in    = bf_ff;
      bl_in    = bl_ff;
      count_in = count_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            abfa_pkg::REG_KERNEL_FIRST: begin
               kf_in = csr_chan.wdata[EA-1:PAGE_SHIFT];
            end
            abfa_pkg::REG_KERNEL_LAST: begin
               kl_in = csr_chan.wdata[EA-1:PAGE_SHIFT];
            end
            abfa_pkg::REG_BOOT_FIRST: begin
               bf_in = csr_chan.wdata[EA-1:PAGE_SHIFT];
            end
            abfa_pkg::REG_BOOT_LAST: begin
               bl_in = csr_chan.wdata[EA-1:PAGE_SHIFT];
            end
            abfa_pkg::REG_AREA_COUNT: begin
               count_in = csr_chan.wdata[CW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cursor_in       = cursor_ff;
      chosen_in       = chosen_ff;
      chosen_valid_in = chosen_valid_ff;
      scan_in         = scan_ff;
      eval_v_in       = eval_v_ff;
      eval_idx_in     = eval_idx_ff;
      found_in        = found_ff;
      best_in         = best_ff;
      res_frame_in    = res_frame_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_frame_in    = rsp_frame_ff;
      rsp_status_in   = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_chan.func == abfa_pkg::FUNC_ALLOC) ? ST_ALLOC : ST_LOAD;
            end
         end
         ST_LOAD: begin
            res_frame_in  = '0;
            res_status_in = abfa_pkg::STATUS_LOADED;
            state_in      = ST_DONE;
         end
         ST_ALLOC: begin
            if (usable) begin
               state_in = ST_FETCH;
            end else begin
               chosen_valid_in = 1'b0;
               scan_in         = '0;
               eval_v_in       = 1'b0;
               found_in        = 1'b0;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in  = 1'b1;
               best_in   = rd_first;
               chosen_in = eval_idx_ff;
            end
            if (scan_more) begin
               eval_v_in   = 1'b1;
               eval_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               eval_v_in = 1'b0;
               if (!eval_v_ff) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            chosen_valid_in = found_ff;
            if (found_ff) begin
               if (cursor_ff < {1'b0, best_ff}) begin
                  cursor_in = {1'b0, best_ff};
               end
               state_in = ST_FETCH;
            end else begin
               res_frame_in  = '0;
               res_status_in = abfa_pkg::STATUS_NO_FRAME;
               state_in      = ST_DONE;
            end
         end
         ST_FETCH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (past_end) begin
               chosen_valid_in = 1'b0;
               state_in        = ST_ALLOC;
            end else begin
               cursor_in = inc_out;
               if (!in_kernel && !in_boot) begin
                  res_frame_in  = cursor_ff[FRAME_W-1:0];
                  res_status_in = abfa_pkg::STATUS_OK;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = FNW'(res_frame_ff);
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         kf_ff           <= '0;
         kl_ff           <= '0;
         bf_ff           <= '0;
         bl_ff           <= '0;
         count_ff        <= '0;
         cursor_ff       <= '0;
         chosen_ff       <= '0;
         chosen_valid_ff <= 1'b0;
         scan_ff         <= '0;
         eval_v_ff       <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         kf_ff           <= kf_in;
         kl_ff           <= kl_in;
         bf_ff           <= bf_in;
         bl_ff           <= bl_in;
         count_ff        <= count_in;
         cursor_ff       <= cursor_in;
         chosen_ff       <= chosen_in;
         chosen_valid_ff <= chosen_valid_in;
         scan_ff         <= scan_in;
         eval_v_ff       <= eval_v_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_chan.func;
         idx_ff  <= req_chan.entry_index;
         base_ff <= req_chan.area_base;
         len_ff  <= req_chan.area_length;
      end
      eval_idx_ff   <= eval_idx_in;
      best_ff       <= best_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_number = rsp_frame_ff;
   assign rsp_chan.status       = rsp_status_ff;

`ifndef SYNTH
   // allocate requests never reach the load path
   a_load_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (func_ff == abfa_pkg::FUNC_LOAD))
      else $error("load state entered for an allocate request");

   // frame checks only run against a chosen area
   a_check_chosen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> chosen_valid_ff)
      else $error("frame check without a chosen area");

   // the cursor never moves backwards while a request is in flight
   a_cursor_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> (cursor_ff >= $past(cursor_ff)))
      else $error("cursor moved backwards");

   // after a successful search the cursor sits at or above the chosen area's first frame
   a_pick_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && found_ff) |=> (cursor_ff >= {1'b0, $past(best_ff)}))
      else $error("cursor below chosen area after search");

   // an allocated frame is only reported with an area chosen
   a_ok_chosen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_status_ff == abfa_pkg::STATUS_OK) |-> chosen_valid_ff)
      else $error("frame allocated without a chosen area");
`endif

endmodule
